// ----- hw/rtl/pema_pkg.sv -----
// ----------------------------------------------------------------------------
// pema_pkg: shared constants for the pressure EMA block
// Calibration run length, datapath widths, step counts of the serial units
// and configuration register indexes.
// ----------------------------------------------------------------------------
package pema_pkg;

  // Calibration run length and acceptance threshold
  localparam int CAL_SAMPLES = 200;
  localparam int CAL_HALF    = CAL_SAMPLES / 2;

  // Widths fixed by the field and state definitions
  localparam int CNT_W  = 11;
  localparam int ACC_W  = 27;
  localparam int DIVD_W = ACC_W - 1;   // magnitude plus rounding term
  localparam int STEP_W = 5;

  // Bit-serial unit step counts
  localparam int MUL_STEPS = 16;       // one per gain bit
  localparam int EMA_STEPS = 9;        // one per alpha bit
  localparam int DIV_STEPS = DIVD_W;   // one quotient bit per step

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] EMA_LAST = STEP_W'(EMA_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd4;

  // Register reset values
  localparam logic [15:0] GAIN_RST     = 16'd22904;
  localparam logic [8:0]  ALPHA_RST    = 9'd77;
  localparam logic [15:0] CLAMP_HI_RST = 16'sd20480;
  localparam logic [15:0] CLAMP_LO_RST = -16'sd20480;

endpackage

// ----- hw/rtl/pressure_ema_with_zero_calibration.sv -----
// ----------------------------------------------------------------------------
// pressure_ema_with_zero_calibration: pressure conversion, EMA and zero cal
// Converts 12-bit differential pressure codes to 1/256 cmH2O, removes the
// zero offset, clamps, filters with an EMA and runs zero calibration.
// ----------------------------------------------------------------------------
// One request is worked on at a time. After acceptance the conversion product
// comes from a bit-serial shift-add multiplier (one gain bit per step), then
// a state for polarity, offset and clamp and a state that loads the output
// register once it is free. A valid measure request adds a serial EMA multiply
// and an update state. A failed measure read or a calibration request skips
// the EMA; the request that ends a run adds a run-end check, and an accepted
// run adds a restoring divider (one quotient bit per step) and a sign step.
// in_stall is high while a request is in work and drops as the result is
// loaded, so the next request can be taken as soon as it drops; the result
// sits in an output register, so a new request may be taken while the
// previous result still waits on out_stall.
module pressure_ema_with_zero_calibration
  import pema_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [11:0]          in_sample,
  input  logic                 in_read_ok,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_filtered_pressure,
  output logic signed [15:0]   out_instant_pressure,
  output logic signed [15:0]   out_offset_now,
  output logic                 out_cal_finished,
  output logic                 out_offset_accepted
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_CLAMP  = 9'b000000100,
    S_EMA    = 9'b000001000,
    S_EMAUPD = 9'b000010000,
    S_CALEND = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_DIVEND = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  // Configuration registers
  logic [15:0]        gain_r;
  logic [8:0]         alpha_r;
  logic signed [15:0] clamp_hi_r;
  logic signed [15:0] clamp_lo_r;
  logic               pol_r;

  // Control and datapath registers
  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               mode_r, mode_nxt;
  logic               ok_r, ok_nxt;
  logic signed [16:0] mcand_r, mcand_nxt;
  logic signed [17:0] mul_hi_r, mul_hi_nxt;
  logic [15:0]        mul_lo_r, mul_lo_nxt;
  logic [10:0]        rem_r, rem_nxt;
  logic [DIVD_W-1:0]  quo_r, quo_nxt;
  logic signed [15:0] inst_r, inst_nxt;
  logic               fin_r, fin_nxt;
  logic               accp_r, accp_nxt;

  // Filter and calibration state
  logic signed [15:0]      ema_r, ema_nxt;
  logic signed [15:0]      offset_r, offset_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        vcnt_r, vcnt_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_fp_r, out_fp_nxt;
  logic signed [15:0] out_ip_r, out_ip_nxt;
  logic signed [15:0] out_off_r, out_off_nxt;
  logic               out_fin_r, out_fin_nxt;
  logic               out_accp_r, out_accp_nxt;

  // Datapath intermediates
  logic               in_take;
  logic               out_free;
  logic signed [13:0] diff_code;
  logic signed [17:0] mul_sum;
  logic signed [18:0] conv_p;
  logic signed [18:0] pol_p;
  logic signed [18:0] off_p;
  logic signed [18:0] hi_p;
  logic signed [18:0] lo_p;
  logic signed [15:0] inst_val;
  logic [8:0]         alpha_eff;
  logic signed [16:0] ema_diff;
  logic signed [26:0] ema_prod;
  logic signed [26:0] ema_rnd;
  logic signed [18:0] ema_sum;
  logic [CNT_W-1:0]   cnt_inc;
  logic [ACC_W-1:0]   acc_mag;
  logic [DIVD_W-1:0]  dividend;
  logic [11:0]        trial;
  logic [11:0]        trial_sub;
  logic               trial_ge;
  logic [16:0]        quo_neg;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RST;
      alpha_r    <= ALPHA_RST;
      clamp_hi_r <= CLAMP_HI_RST;
      clamp_lo_r <= CLAMP_LO_RST;
      pol_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:     gain_r     <= cfg_wdata;
        REG_ALPHA:    alpha_r    <= cfg_wdata[8:0];
        REG_CLAMP_HI: clamp_hi_r <= cfg_wdata;
        REG_CLAMP_LO: clamp_lo_r <= cfg_wdata;
        REG_POLARITY: pol_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign out_filtered_pressure = out_fp_r;
  assign out_instant_pressure  = out_ip_r;
  assign out_offset_now        = out_off_r;
  assign out_cal_finished      = out_fin_r;
  assign out_offset_accepted   = out_accp_r;

  // Centered ADC code: 2*sample - 4095
  assign diff_code = $signed({1'b0, in_sample, 1'b0}) - 14'sd4095;

  // Shared shift-add step: add multiplicand on multiplier LSB
  assign mul_sum = mul_lo_r[0] ? (mul_hi_r + {mcand_r[16], mcand_r}) : mul_hi_r;

  // Conversion product bits 29:12 give the floor of product / 4096
  assign conv_p = {mul_hi_r[13], mul_hi_r[13:0], mul_lo_r[15:12]};
  assign pol_p  = pol_r ? -conv_p : conv_p;
  assign off_p  = mode_r ? pol_p : (pol_p - {{3{offset_r[15]}}, offset_r});

  // Upper limit first, then lower limit
  assign hi_p     = (off_p > $signed({{3{clamp_hi_r[15]}}, clamp_hi_r}))
                    ? {{3{clamp_hi_r[15]}}, clamp_hi_r} : off_p;
  assign lo_p     = (hi_p < $signed({{3{clamp_lo_r[15]}}, clamp_lo_r}))
                    ? {{3{clamp_lo_r[15]}}, clamp_lo_r} : hi_p;
  assign inst_val = ok_r ? lo_p[15:0] : 16'sd0;

  // EMA as ema + round(alpha * (inst - ema) / 256)
  assign alpha_eff = (alpha_r > 9'd256) ? 9'd256 : alpha_r;
  assign ema_diff  = {inst_val[15], inst_val} - {ema_r[15], ema_r};
  assign ema_prod  = {mul_hi_r, mul_lo_r[15:7]};
  assign ema_rnd   = ema_prod + 27'sd128;
  assign ema_sum   = {{3{ema_r[15]}}, ema_r} + ema_rnd[26:8];

  // Calibration count and rounded-mean dividend
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign acc_mag  = acc_r[ACC_W-1] ? (-acc_r) : acc_r;
  assign dividend = acc_mag[DIVD_W-1:0] + DIVD_W'(vcnt_r[CNT_W-1:1]);

  // Restoring divide step
  assign trial     = {rem_r, quo_r[DIVD_W-1]};
  assign trial_ge  = (trial >= {1'b0, vcnt_r});
  assign trial_sub = trial - {1'b0, vcnt_r};
  assign quo_neg   = -quo_r[16:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    ok_nxt        = ok_r;
    mcand_nxt     = mcand_r;
    mul_hi_nxt    = mul_hi_r;
    mul_lo_nxt    = mul_lo_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    inst_nxt      = inst_r;
    fin_nxt       = fin_r;
    accp_nxt      = accp_r;
    ema_nxt       = ema_r;
    offset_nxt    = offset_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    vcnt_nxt      = vcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_fp_nxt    = out_fp_r;
    out_ip_nxt    = out_ip_r;
    out_off_nxt   = out_off_r;
    out_fin_nxt   = out_fin_r;
    out_accp_nxt  = out_accp_r;

    unique case (state_r)
      // Take a request and load the conversion multiply
      S_IDLE: begin
        if (in_take) begin
          mode_nxt   = in_mode;
          ok_nxt     = in_read_ok;
          mcand_nxt  = {{3{diff_code[13]}}, diff_code};
          mul_hi_nxt = 18'sd0;
          mul_lo_nxt = gain_r;
          step_nxt   = MUL_LAST;
          fin_nxt    = 1'b0;
          accp_nxt   = 1'b0;
          state_nxt  = S_MUL;
        end
      end

      // Advance one multiplier bit; also serves the EMA multiply
      S_MUL, S_EMA: begin
        {mul_hi_nxt, mul_lo_nxt} = {mul_sum[17], mul_sum, mul_lo_r[15:1]};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = (state_r == S_MUL) ? S_CLAMP : S_EMAUPD;
        end
      end

      // Polarity, offset, clamp; branch on mode
      S_CLAMP: begin
        inst_nxt = inst_val;
        if (!mode_r) begin
          if (ok_r) begin
            mcand_nxt  = ema_diff;
            mul_hi_nxt = 18'sd0;
            mul_lo_nxt = {7'd0, alpha_eff};
            step_nxt   = EMA_LAST;
            state_nxt  = S_EMA;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          acc_nxt  = acc_r + {{(ACC_W-16){inst_val[15]}}, inst_val};
          vcnt_nxt = vcnt_r + CNT_W'(ok_r);
          cnt_nxt  = cnt_inc;
          state_nxt = (cnt_inc >= CNT_W'(CAL_SAMPLES)) ? S_CALEND : S_OUT;
        end
      end

      // Fold the rounded product into the EMA
      S_EMAUPD: begin
        ema_nxt   = ema_sum[15:0];
        state_nxt = S_OUT;
      end

      // End of run: divide if enough valid samples, else drop the offset
      S_CALEND: begin
        fin_nxt = 1'b1;
        if (vcnt_r > CNT_W'(CAL_HALF)) begin
          rem_nxt   = '0;
          quo_nxt   = dividend;
          step_nxt  = DIV_LAST;
          state_nxt = S_DIV;
        end else begin
          offset_nxt = 16'sd0;
          acc_nxt    = '0;
          cnt_nxt    = '0;
          vcnt_nxt   = '0;
          state_nxt  = S_OUT;
        end
      end

      // One quotient bit per cycle
      S_DIV: begin
        rem_nxt  = trial_ge ? trial_sub[10:0] : trial[10:0];
        quo_nxt  = {quo_r[DIVD_W-2:0], trial_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_DIVEND;
        end
      end

      // Apply sign, store offset, clear the run
      S_DIVEND: begin
        offset_nxt = acc_r[ACC_W-1] ? quo_neg[15:0] : quo_r[15:0];
        accp_nxt   = 1'b1;
        acc_nxt    = '0;
        cnt_nxt    = '0;
        vcnt_nxt   = '0;
        state_nxt  = S_OUT;
      end

      // Hold until the output register is free
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fp_nxt    = ema_r;
          out_ip_nxt    = inst_r;
          out_off_nxt   = offset_r;
          out_fin_nxt   = fin_r;
          out_accp_nxt  = accp_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ema_r       <= '0;
      offset_r    <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      vcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ema_r       <= ema_nxt;
      offset_r    <= offset_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      vcnt_r      <= vcnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    mode_r     <= mode_nxt;
    ok_r       <= ok_nxt;
    mcand_r    <= mcand_nxt;
    mul_hi_r   <= mul_hi_nxt;
    mul_lo_r   <= mul_lo_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    inst_r     <= inst_nxt;
    fin_r      <= fin_nxt;
    accp_r     <= accp_nxt;
    out_fp_r   <= out_fp_nxt;
    out_ip_r   <= out_ip_nxt;
    out_off_r  <= out_off_nxt;
    out_fin_r  <= out_fin_nxt;
    out_accp_r <= out_accp_nxt;
  end

`ifndef SYNTHESIS
  // An accepted offset is only reported with the end of a run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_offset_accepted |-> out_cal_finished)
    else $error("offset accepted without end of calibration run");

  // Between requests the run count is below the run length
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cnt_r < CNT_W'(CAL_SAMPLES))
    else $error("calibration count not cleared at end of run");

  // Valid samples never outnumber counted samples
  assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= cnt_r)
    else $error("valid count exceeds sample count");

  // An accepted request starts the conversion multiply
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_MUL && step_r == MUL_LAST)
    else $error("accepted request did not start conversion");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pressure EMA with zero calibration
// Drives ADC requests with random gaps and result stalls. A local predictor
// keeps its own copy of the registers, the filter state and the calibration
// run, and every result is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import pema_pkg::*;

  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_CAL     = 1'b1;

  typedef struct packed {
    logic [15:0] filtered;
    logic [15:0] instant;
    logic [15:0] offset;
    logic        finished;
    logic        accepted;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_mode;
  logic [11:0]          in_sample;
  logic                 in_read_ok;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [15:0]   out_filtered_pressure;
  logic signed [15:0]   out_instant_pressure;
  logic signed [15:0]   out_offset_now;
  logic                 out_cal_finished;
  logic                 out_offset_accepted;

  // register copy
  logic [15:0]        gain_r;
  logic [8:0]         alpha_r;
  logic signed [15:0] clamp_hi_r;
  logic signed [15:0] clamp_lo_r;
  logic               invert_r;

  // filter and calibration state
  longint ema_q;
  longint offset_q;
  longint cal_sum;
  int     cal_count;
  int     cal_good;

  reading_t pending_readings[$];
  int       errors;
  int       gap_pct;
  int       stall_pct;
  int       stall_left;

  pressure_ema_with_zero_calibration dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mode               (in_mode),
    .in_sample             (in_sample),
    .in_read_ok            (in_read_ok),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_filtered_pressure (out_filtered_pressure),
    .out_instant_pressure  (out_instant_pressure),
    .out_offset_now        (out_offset_now),
    .out_cal_finished      (out_cal_finished),
    .out_offset_accepted   (out_offset_accepted)
  );

  always #5 clk = ~clk;

  // Code to pressure: floor of the scaled product, polarity, offset, limits
  function automatic longint convert_code(logic [11:0] code, longint offs);
    longint p;
    p = (2 * longint'(code) - 4095) * longint'(gain_r);
    p = p >>> 12;
    if (invert_r) p = -p;
    p = p - offs;
    if (p > longint'(clamp_hi_r)) p = clamp_hi_r;
    if (p < longint'(clamp_lo_r)) p = clamp_lo_r;
    return p;
  endfunction

  // Advance the filter or the calibration run by one request
  function automatic reading_t predict_pressure(logic mode, logic [11:0] code, logic ok);
    reading_t r;
    longint   inst;
    longint   a;
    longint   mag;
    longint   q;
    r = '0;
    inst = 0;
    if (mode == MODE_MEASURE) begin
      if (ok) begin
        inst = convert_code(code, offset_q);
        a = (alpha_r > 9'd256) ? 256 : longint'(alpha_r);
        ema_q = (a * inst + (256 - a) * ema_q + 128) >>> 8;
      end
    end else begin
      if (ok) begin
        inst = convert_code(code, 0);
        cal_sum += inst;
        cal_good++;
      end
      cal_count++;
      if (cal_count >= CAL_SAMPLES) begin
        r.finished = 1'b1;
        // rounded mean, ties away from zero
        if (cal_good > CAL_HALF) begin
          mag = (cal_sum < 0) ? -cal_sum : cal_sum;
          q = (mag + cal_good / 2) / cal_good;
          offset_q = (cal_sum < 0) ? -q : q;
          r.accepted = 1'b1;
        end else begin
          offset_q = 0;
        end
        cal_sum = 0;
        cal_count = 0;
        cal_good = 0;
      end
    end
    r.filtered = ema_q[15:0];
    r.instant  = inst[15:0];
    r.offset   = offset_q[15:0];
    return r;
  endfunction

  // Code around zero pressure, shifted by bias
  function automatic logic [11:0] near_code(int bias, int spread);
    int c;
    c = 2048 + bias + int'($urandom_range(2 * spread)) - spread;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c[11:0];
  endfunction

  // Present one request, hold it until taken, then record its expected result
  task automatic send_sample(input logic mode, input logic [11:0] code, input logic ok);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_sample  <= code;
    in_read_ok <= ok;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(predict_pressure(mode, code, ok));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers once the block is idle
  task automatic set_config(input logic [15:0] gain, input logic [8:0] alpha,
                            input logic signed [15:0] hi, input logic signed [15:0] lo,
                            input logic pol);
    logic [CFG_IDX_W-1:0] regs [5] = '{REG_GAIN, REG_ALPHA, REG_CLAMP_HI,
                                       REG_CLAMP_LO, REG_POLARITY};
    logic [15:0]          vals [5];
    vals = '{gain, {7'd0, alpha}, hi, lo, {15'd0, pol}};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    gain_r     = gain;
    alpha_r    = alpha;
    clamp_hi_r = hi;
    clamp_lo_r = lo;
    invert_r   = pol;
  endtask

  task automatic load_random_config();
    logic [15:0]        gain;
    logic [8:0]         alpha;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    case ($urandom_range(3))
      0:       gain = 16'($urandom());
      1:       gain = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: gain = 16'(int'(GAIN_RST) + int'($urandom_range(4000)) - 2000);
    endcase
    alpha = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(256));
    if ($urandom_range(5) == 0) begin
      // limits in any order, crossed ones included
      hi = 16'($urandom());
      lo = 16'($urandom());
    end else begin
      hi = 16'($urandom_range(32767));
      lo = 16'(-int'($urandom_range(32768)));
    end
    set_config(gain, alpha, hi, lo, 1'($urandom_range(1)));
  endtask

  task automatic run_measure(input int count, input int bias, input int spread);
    repeat (count) send_sample(MODE_MEASURE, near_code(bias, spread), $urandom_range(9) != 0);
  endtask

  // Complete the current calibration run with the given number of good reads, capped by what is left of the run
  task automatic run_calibration(input int good_total, input int bias, input int spread,
                                 input int measure_pct);
    int   left;
    int   need;
    logic ok;
    left = CAL_SAMPLES - cal_count;
    need = good_total - cal_good;
    if (need > left) need = left;
    if (need < 0) need = 0;
    while (left > 0) begin
      if ($urandom_range(99) < measure_pct) begin
        send_sample(MODE_MEASURE, near_code(bias, spread), $urandom_range(9) != 0);
      end else begin
        ok = $urandom_range(left - 1) < need;
        if (ok) need--;
        left--;
        send_sample(MODE_CAL, near_code(bias, spread), ok);
      end
    end
  endtask

  task automatic send_random_sample();
    logic [11:0] code;
    code = $urandom_range(1) ? 12'($urandom_range(4095))
                             : near_code(int'($urandom_range(800)) - 400, 30);
    send_sample(($urandom_range(9) < 3) ? MODE_CAL : MODE_MEASURE, code,
                $urandom_range(9) != 0);
  endtask

  // Code extremes, failed reads and a calibration run left open
  task automatic test_conversion_extremes();
    gap_pct   = 30;
    stall_pct = 30;
    send_sample(MODE_MEASURE, 12'd0, 1'b1);
    send_sample(MODE_MEASURE, 12'hFFF, 1'b1);
    send_sample(MODE_MEASURE, 12'd2047, 1'b1);
    send_sample(MODE_MEASURE, 12'd2048, 1'b1);
    send_sample(MODE_MEASURE, 12'hAAA, 1'b1);
    send_sample(MODE_MEASURE, 12'h555, 1'b1);
    send_sample(MODE_MEASURE, 12'hFFF, 1'b0);
    send_sample(MODE_CAL, 12'hFFF, 1'b1);
    send_sample(MODE_CAL, 12'd0, 1'b0);
    send_sample(MODE_MEASURE, 12'd1000, 1'b1);
  endtask

  // Gain and alpha extremes, alpha above 256, inversion, crossed limits
  task automatic test_register_corners();
    set_config(16'hFFFF, 9'd256, 16'h7FFF, 16'h8000, 1'b0);
    send_sample(MODE_MEASURE, 12'hFFF, 1'b1);
    send_sample(MODE_MEASURE, 12'd0, 1'b1);
    set_config(16'd0, 9'd0, 16'h7FFF, 16'h8000, 1'b0);
    send_sample(MODE_MEASURE, 12'hFFF, 1'b1);
    set_config(16'd4096, 9'd511, 16'sd20480, -16'sd20480, 1'b1);
    send_sample(MODE_MEASURE, 12'd0, 1'b1);
    send_sample(MODE_MEASURE, 12'hFFF, 1'b1);
    set_config(GAIN_RST, 9'd300, -16'sd100, 16'sd100, 1'b0);
    send_sample(MODE_MEASURE, 12'hFFF, 1'b1);
    send_sample(MODE_MEASURE, 12'd0, 1'b1);
    set_config(16'd1, 9'd1, 16'sd20480, -16'sd20480, 1'b1);
    send_sample(MODE_MEASURE, 12'd2047, 1'b1);
    send_sample(MODE_MEASURE, 12'd2048, 1'b1);
  endtask

  // Full runs: accepted, rejected at the threshold, interrupted, clamped
  task automatic test_calibration_runs();
    set_config(GAIN_RST, ALPHA_RST, CLAMP_HI_RST, CLAMP_LO_RST, 1'b0);
    run_calibration(CAL_SAMPLES, 300, 60, 0);
    run_measure(20, 300, 80);
    run_calibration(CAL_HALF, 100, 40, 0);
    run_measure(20, 100, 40);
    run_calibration(CAL_HALF + 1, -200, 50, 0);
    set_config(GAIN_RST, 9'd128, CLAMP_HI_RST, CLAMP_LO_RST, 1'b1);
    run_calibration(180, -500, 100, 15);
    run_measure(20, -500, 100);
    run_calibration(150, 0, 2047, 5);
  endtask

  // Phases of random registers, requests and idling
  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      load_random_config();
      gap_pct   = 30 * $urandom_range(2);
      stall_pct = 30 * $urandom_range(2);
      repeat (100) send_random_sample();
    end
  endtask

  // Back to back requests with no idling on either side
  task automatic test_full_rate();
    load_random_config();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (250) send_random_sample();
  endtask

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, $signed(want), $signed(got));
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual filtered=%0d instant=%0d offset=%0d",
                 $time, out_filtered_pressure, out_instant_pressure, out_offset_now);
      end else begin
        want = pending_readings.pop_front();
        compare_field("filtered_pressure", want.filtered, out_filtered_pressure);
        compare_field("instant_pressure", want.instant, out_instant_pressure);
        compare_field("offset_now", want.offset, out_offset_now);
        compare_field("cal_finished", {15'd0, want.finished}, {15'd0, out_cal_finished});
        compare_field("offset_accepted", {15'd0, want.accepted},
                      {15'd0, out_offset_accepted});
      end
    end
  end

  // Hard limit on run time
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_GAIN;
    cfg_wdata  = 16'd0;
    in_valid   = 1'b0;
    in_mode    = MODE_MEASURE;
    in_sample  = 12'd0;
    in_read_ok = 1'b0;
    out_stall  = 1'b0;
    stall_left = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    errors     = 0;
    gain_r     = GAIN_RST;
    alpha_r    = ALPHA_RST;
    clamp_hi_r = CLAMP_HI_RST;
    clamp_lo_r = CLAMP_LO_RST;
    invert_r   = 1'b0;
    ema_q      = 0;
    offset_q   = 0;
    cal_sum    = 0;
    cal_count  = 0;
    cal_good   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_conversion_extremes();
    test_register_corners();
    test_calibration_runs();
    test_random_mix();
    test_full_rate();
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
